FILE: rtl/tsm_pkg.sv
package tsm_pkg;

	// Largest image the line stores and counters are built for.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	// Counter widths follow from the largest image.
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	// Fixed field widths of the ports.
	localparam int PIX_W      = 8;
	localparam int SIZE_W     = 11;
	localparam int TMPL_W     = 24;
	localparam int SCORE_W    = 20;
	localparam int POS_W      = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int SQ_W       = 2 * PIX_W;
	localparam int LINE_W     = 2 * PIX_W;

	// Compare widths wide enough for a counter plus one and a size register.
	localparam int COL_CMP_W = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W;
	localparam int ROW_CMP_W = (ROW_W + 1 > SIZE_W) ? ROW_W + 1 : SIZE_W;

	// Output queue sizing.
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int OCC_W      = $clog2(FIFO_DEPTH + 5);

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = CFG_IDX_W'(0),
		REG_IMAGE_HEIGHT = CFG_IDX_W'(1),
		REG_TMPL_TOP     = CFG_IDX_W'(2),
		REG_TMPL_MID     = CFG_IDX_W'(3),
		REG_TMPL_BOT     = CFG_IDX_W'(4)
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;

	// Window pixels indexed [row][col], row 0 on top, col 0 on the left.
	typedef logic [2:0][2:0][PIX_W-1:0] window_t;

	// Template rows indexed [row], left value in the low byte.
	typedef logic [2:0][TMPL_W-1:0] tmpl_t;

	// Effective configuration seen by the datapath.
	typedef struct packed {
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
		tmpl_t             tmpl;
	} cfg_t;

	// Position information that travels with each window.
	typedef struct packed {
		logic [POS_W-1:0] win_row;
		logic [POS_W-1:0] win_col;
		logic             frame_last;
	} tag_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		tag_t               tag;
	} result_t;

	// Occupancy of the two pipeline stages inside a module.
	typedef struct packed {
		logic first;
		logic second;
	} stage_busy_t;

endpackage

FILE: rtl/tsm_ram.sv
module tsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/tsm_line_window.sv
module tsm_line_window
	import tsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  pix_t        pixel,
	input  cfg_t        cfg,
	output window_t     win,
	output tag_t        tag,
	output logic        win_valid,
	output stage_busy_t busy
);

	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [COL_CMP_W-1:0] col_inc;
	logic [ROW_CMP_W-1:0] row_inc;
	logic                 col_wrap;
	logic                 row_wrap;
	logic                 produce;
	tag_t                 tag_in;

	logic             v_s1;
	logic             produce_s1;
	pix_t             px_s1;
	logic [COL_W-1:0] addr_s1;
	tag_t             tag_s1;

	logic             v_s2;
	tag_t             tag_s2;
	window_t          win_q;

	logic [LINE_W-1:0] ram_rdata;
	logic [LINE_W-1:0] ram_wdata;
	pix_t              rd_above2;
	pix_t              rd_above1;

	// Next column and row, with wrap at the configured size.
	always_comb begin
		col_inc  = COL_CMP_W'(col_q) + COL_CMP_W'(1);
		row_inc  = ROW_CMP_W'(row_q) + ROW_CMP_W'(1);
		col_wrap = col_inc >= COL_CMP_W'(cfg.width);
		row_wrap = row_inc >= ROW_CMP_W'(cfg.height);
	end

	// A window that lies fully inside the image yields a result.
	always_comb begin
		produce           = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
		tag_in.win_row    = POS_W'(row_q - ROW_W'(2));
		tag_in.win_col    = POS_W'(col_q - COL_W'(2));
		tag_in.frame_last = (ROW_CMP_W'(row_q) == ROW_CMP_W'(cfg.height) - ROW_CMP_W'(1))
			&& (COL_CMP_W'(col_q) == COL_CMP_W'(cfg.width) - COL_CMP_W'(1));
	end

	// Raster position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : ROW_W'(row_inc);
			end else begin
				col_q <= COL_W'(col_inc);
			end
		end
	end

	// Stage 1 waits for the line store read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			produce_s1 <= produce;
			px_s1      <= pixel;
			addr_s1    <= col_q;
			tag_s1     <= tag_in;
		end
	end

	// Both line stores share one memory word: upper byte is two rows up.
	assign rd_above2 = ram_rdata[LINE_W-1:PIX_W];
	assign rd_above1 = ram_rdata[PIX_W-1:0];
	assign ram_wdata = {rd_above1, px_s1};

	tsm_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (v_s1),
		.waddr (addr_s1),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	// Window shift: the new column enters on the right.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (v_s1) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= win_q[k][2];
			end
			win_q[0][2] <= rd_above2;
			win_q[1][2] <= rd_above1;
			win_q[2][2] <= px_s1;
		end
	end

	// Stage 2 holds the finished window for the score unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && produce_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			tag_s2 <= tag_s1;
		end
	end

	assign win         = win_q;
	assign tag         = tag_s2;
	assign win_valid   = v_s2;
	assign busy.first  = v_s1;
	assign busy.second = v_s2;

`ifndef ASSERT_OFF
	// A write back never lands on the entry being read in the same cycle.
	a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && accept) |-> (addr_s1 != col_q))
		else $error("line store write and read hit the same entry");
`endif

endmodule

FILE: rtl/tsm_ssd.sv
module tsm_ssd
	import tsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        win_valid,
	input  window_t     win,
	input  tag_t        tag,
	input  tmpl_t       tmpl,
	output logic        res_valid,
	output result_t     res,
	output stage_busy_t busy
);

	logic [2:0][2:0][PIX_W-1:0] diff;
	logic [2:0][2:0][SQ_W-1:0]  sq_s3;
	logic                       v_s3;
	tag_t                       tag_s3;

	logic [2:0][SCORE_W-1:0] row_sum;
	logic [SCORE_W-1:0]      total;
	logic                    v_s4;
	result_t                 res_s4;

	// Absolute difference of each window pixel and its template value.
	always_comb begin
		for (int m = 0; m < 3; m++) begin
			for (int n = 0; n < 3; n++) begin
				if (win[m][n] >= tmpl[m][n*PIX_W +: PIX_W]) begin
					diff[m][n] = win[m][n] - tmpl[m][n*PIX_W +: PIX_W];
				end else begin
					diff[m][n] = tmpl[m][n*PIX_W +: PIX_W] - win[m][n];
				end
			end
		end
	end

	// Stage 3: nine squares in parallel lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= win_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (win_valid) begin
			for (int m = 0; m < 3; m++) begin
				for (int n = 0; n < 3; n++) begin
					sq_s3[m][n] <= SQ_W'(diff[m][n]) * SQ_W'(diff[m][n]);
				end
			end
			tag_s3 <= tag;
		end
	end

	// Adder tree: three row sums, then the total.
	always_comb begin
		for (int m = 0; m < 3; m++) begin
			row_sum[m] = SCORE_W'(sq_s3[m][0]) + SCORE_W'(sq_s3[m][1])
				+ SCORE_W'(sq_s3[m][2]);
		end
		total = row_sum[0] + row_sum[1] + row_sum[2];
	end

	// Stage 4 holds the finished result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			res_s4.score <= total;
			res_s4.tag   <= tag_s3;
		end
	end

	assign res_valid   = v_s4;
	assign res         = res_s4;
	assign busy.first  = v_s3;
	assign busy.second = v_s4;

`ifndef ASSERT_OFF
	// Every window that enters leaves as a result through stages 3 and 4.
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		win_valid |-> ##2 res_valid)
		else $error("score pipeline lost a window");
`endif

endmodule

FILE: rtl/tsm_out_fifo.sv
module tsm_out_fifo
	import tsm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  result_t          push_data,
	input  logic             pop,
	output result_t          pop_data,
	output logic             not_empty,
	output logic [CNT_W-1:0] count
);

	result_t          entry_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign pop_data  = entry_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign count     = count_q;

`ifndef ASSERT_OFF
	// The input credit keeps the queue from overflowing.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CNT_W'(FIFO_DEPTH)) |-> !push)
		else $error("result queue overflow");

	// A result leaves only when one is held.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("result queue underflow");
`endif

endmodule

FILE: rtl/template_ssd_match_top.sv
// 3x3 sum-of-squared-differences template matcher. Pixels enter in raster order at one
// item per clock while in_stall is low; for each window position fully inside the image
// one result leaves with its score, the window's top-left row and column, and a flag on
// the frame's last window. Edge positions in the first two rows and columns give no result.
// The two previous rows live in one 1024 x 16 memory that is read at accept and written
// back the next cycle, so the rate of one pixel per clock is set by that single read and
// write port pair. A result passes the line window and score stages and waits in an
// eight-entry queue; input stalls once the queued results plus the items in the four
// pipeline stages reach eight, the depth of the queue. The line memory needs no clearing
// pass after reset. Configuration (image size, template rows) is to be written through
// the cfg port while the block is idle, which it does not enforce; sizes are clamped to 3..1024.
module template_ssd_match_top
	import tsm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIX_W-1:0]      pixel,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [SCORE_W-1:0]    score,
	output logic [POS_W-1:0]      win_row,
	output logic [POS_W-1:0]      win_col,
	output logic                  frame_last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	tmpl_t             tmpl_q;
	cfg_t              cfg_eff;

	logic        accept;
	logic        pop;
	window_t     win;
	tag_t        win_tag;
	logic        win_valid;
	stage_busy_t lw_busy;
	stage_busy_t ssd_busy;
	logic        res_valid;
	result_t     res;
	result_t     head;
	logic [CNT_W-1:0] fifo_count;
	logic [OCC_W-1:0] occupancy;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= SIZE_W'(8);
			height_q  <= SIZE_W'(8);
			tmpl_q[0] <= TMPL_W'(24'h010201);
			tmpl_q[1] <= TMPL_W'(24'h000100);
			tmpl_q[2] <= TMPL_W'(24'h000100);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q   <= cfg_data[SIZE_W-1:0];
				REG_IMAGE_HEIGHT: height_q  <= cfg_data[SIZE_W-1:0];
				REG_TMPL_TOP:     tmpl_q[0] <= cfg_data[TMPL_W-1:0];
				REG_TMPL_MID:     tmpl_q[1] <= cfg_data[TMPL_W-1:0];
				REG_TMPL_BOT:     tmpl_q[2] <= cfg_data[TMPL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sizes outside the supported range are clamped.
	always_comb begin
		if (width_q < SIZE_W'(3)) begin
			cfg_eff.width = SIZE_W'(3);
		end else if (width_q > MAX_WIDTH) begin
			cfg_eff.width = SIZE_W'(MAX_WIDTH);
		end else begin
			cfg_eff.width = width_q;
		end
		if (height_q < SIZE_W'(3)) begin
			cfg_eff.height = SIZE_W'(3);
		end else if (height_q > MAX_HEIGHT) begin
			cfg_eff.height = SIZE_W'(MAX_HEIGHT);
		end else begin
			cfg_eff.height = height_q;
		end
		cfg_eff.tmpl = tmpl_q;
	end

	// Input credit: queued results plus every item still in the pipeline.
	always_comb begin
		occupancy = OCC_W'(fifo_count) + OCC_W'(lw_busy.first) + OCC_W'(lw_busy.second)
			+ OCC_W'(ssd_busy.first) + OCC_W'(ssd_busy.second);
	end

	assign in_stall = occupancy >= OCC_W'(FIFO_DEPTH);
	assign accept   = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;

	tsm_line_window u_line_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.pixel     (pixel),
		.cfg       (cfg_eff),
		.win       (win),
		.tag       (win_tag),
		.win_valid (win_valid),
		.busy      (lw_busy)
	);

	tsm_ssd u_ssd (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_valid (win_valid),
		.win       (win),
		.tag       (win_tag),
		.tmpl      (cfg_eff.tmpl),
		.res_valid (res_valid),
		.res       (res),
		.busy      (ssd_busy)
	);

	tsm_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (pop),
		.pop_data  (head),
		.not_empty (out_valid),
		.count     (fifo_count)
	);

	assign score      = head.score;
	assign win_row    = head.tag.win_row;
	assign win_col    = head.tag.win_col;
	assign frame_last = head.tag.frame_last;

endmodule

FILE: test/template_ssd_match_top_tb.sv
module template_ssd_match_top_tb;
	import tsm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 1_500_000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_PIXELS = 200;
	localparam int MAX_IDLE      = 12;
	localparam int HOLD_CYCLES   = 300;

	// First register index past the end of the register list.
	localparam logic [CFG_IDX_W-1:0] FIRST_FREE_INDEX = CFG_IDX_W'(REG_TMPL_BOT + 1);

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [PIX_W-1:0]      pixel;
	logic                  out_valid;
	logic                  out_stall;
	logic [SCORE_W-1:0]    score;
	logic [POS_W-1:0]      win_row;
	logic [POS_W-1:0]      win_col;
	logic                  frame_last;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	template_ssd_match_top uut (.*);

	always #2 clk = ~clk;

	// Shadow copy of the matcher: line stores, window, counters and registers.
	pix_t              rows_two_up [MAX_WIDTH];
	pix_t              rows_one_up [MAX_WIDTH];
	window_t           win_q    = '0;
	int unsigned       col_q    = 0;
	int unsigned       row_q    = 0;
	logic [SIZE_W-1:0] width_q  = SIZE_W'(8);
	logic [SIZE_W-1:0] height_q = SIZE_W'(8);
	// Reset template: top 0x010201, middle and bottom 0x000100.
	tmpl_t             tmpl_q   = {24'h000100, 24'h000100, 24'h010201};

	result_t     pending_windows [$];
	int          mismatch_count  = 0;
	int unsigned accepted_pixels = 0;
	int unsigned cycle_count     = 0;
	bit          tx_idle         = 1'b1;
	bit          rx_idle         = 1'b1;
	int          rx_hold_request = 0;

	function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v,
			input int unsigned maxv);
		if (v < 3) return 3;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic pix_t draw_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return pix_t'($urandom);
		endcase
	endfunction

	// A size value with random bits above the register's width.
	function automatic logic [CFG_DATA_W-1:0] size_word(input int unsigned v);
		logic [CFG_DATA_W-1:0] word;
		word = CFG_DATA_W'($urandom);
		word[SIZE_W-1:0] = SIZE_W'(v);
		return word;
	endfunction

	// Advance the shadow matcher by one pixel and queue the score it yields, if any.
	task automatic ssd_step(input pix_t px);
		int unsigned w, h, c, r, sum;
		int          d;
		pix_t        up2, up1;
		result_t     res;
		w = eff_size(width_q, MAX_WIDTH);
		h = eff_size(height_q, MAX_HEIGHT);
		c = col_q;
		r = row_q;
		if (c >= MAX_WIDTH) c = 0;
		up2 = rows_two_up[c];
		up1 = rows_one_up[c];
		rows_two_up[c] = up1;
		rows_one_up[c] = px;
		for (int k = 0; k < 3; k++) begin
			win_q[k][0] = win_q[k][1];
			win_q[k][1] = win_q[k][2];
		end
		win_q[0][2] = up2;
		win_q[1][2] = up1;
		win_q[2][2] = px;
		if (r >= 2 && c >= 2) begin
			sum = 0;
			for (int m = 0; m < 3; m++) begin
				for (int n = 0; n < 3; n++) begin
					d = int'(win_q[m][n]) - int'(tmpl_q[m][8*n +: 8]);
					sum += d * d;
				end
			end
			res.score          = sum[SCORE_W-1:0];
			res.tag.win_row    = POS_W'(r - 2);
			res.tag.win_col    = POS_W'(c - 2);
			res.tag.frame_last = (r == h - 1) && (c == w - 1);
			pending_windows.push_back(res);
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		col_q = c;
		row_q = r;
	endtask

	// Offer one pixel, after a random gap when tx_idle is set, and hold it until the block takes it.
	task automatic send_pixel(input pix_t px);
		int gap;
		gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel    <= px;
		do @(posedge clk); while (in_stall);
		ssd_step(px);
		accepted_pixels++;
	endtask

	// Send pixels until the counters wrap back to the frame's first position.
	task automatic send_frame(input bit fixed, input pix_t value);
		do send_pixel(fixed ? value : draw_pixel()); while (col_q != 0 || row_q != 0);
	endtask

	// Stop offering items, wait for every expected score, then let the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_windows.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_IMAGE_WIDTH:  width_q   = data[SIZE_W-1:0];
			REG_IMAGE_HEIGHT: height_q  = data[SIZE_W-1:0];
			REG_TMPL_TOP:     tmpl_q[0] = data[TMPL_W-1:0];
			REG_TMPL_MID:     tmpl_q[1] = data[TMPL_W-1:0];
			REG_TMPL_BOT:     tmpl_q[2] = data[TMPL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_sizes(input int unsigned w, input int unsigned h);
		write_reg(REG_IMAGE_WIDTH, size_word(w));
		write_reg(REG_IMAGE_HEIGHT, size_word(h));
	endtask

	task automatic write_template(input logic [TMPL_W-1:0] top, input logic [TMPL_W-1:0] mid,
			input logic [TMPL_W-1:0] bot);
		write_reg(REG_TMPL_TOP, top);
		write_reg(REG_TMPL_MID, mid);
		write_reg(REG_TMPL_BOT, bot);
	endtask

	// Three rows at the reset size and template, with no register written.
	task automatic test_reset_defaults();
		repeat (24) send_pixel(draw_pixel());
		drain();
	endtask

	// Shrink the height and then the width while a frame is under way.
	task automatic test_size_change_mid_frame();
		write_reg(REG_IMAGE_HEIGHT, size_word(4));
		repeat (6) send_pixel(draw_pixel());
		drain();
		// The column counter now sits beyond the new width and must wrap.
		write_reg(REG_IMAGE_WIDTH, size_word(4));
		send_pixel(draw_pixel());
		send_frame(1'b0, '0);
		drain();
	endtask

	// Sizes below three are used as three; each frame has a single window.
	task automatic test_smallest_sizes();
		write_sizes(0, 1);
		send_frame(1'b0, '0);
		drain();
		write_sizes(2, 2);
		send_frame(1'b0, '0);
		drain();
	endtask

	// Largest score in both directions, and a window equal to the template.
	task automatic test_template_extremes();
		pix_t v;
		write_sizes(3, 3);
		write_template('1, '1, '1);
		send_frame(1'b1, '0);
		drain();
		write_template('0, '0, '0);
		send_frame(1'b1, '1);
		drain();
		v = draw_pixel();
		write_template({3{v}}, {3{v}}, {3{v}});
		send_frame(1'b1, v);
		drain();
	endtask

	// A template written between two windows of a frame applies to the next one.
	task automatic test_template_mid_frame();
		write_sizes(4, 3);
		repeat (11) send_pixel(draw_pixel());
		drain();
		write_template(TMPL_W'($urandom), TMPL_W'($urandom), TMPL_W'($urandom));
		send_frame(1'b0, '0);
		drain();
	endtask

	// Writes to indexes past the register list change nothing.
	task automatic test_unused_registers();
		for (int i = FIRST_FREE_INDEX; i < 2 ** CFG_IDX_W; i++)
			write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
		send_frame(1'b0, '0);
		drain();
	endtask

	// A width above the limit is used as the widest row; the row wraps there, and the
	// frame then finishes at a narrow width so that its windows show the wrap.
	task automatic test_largest_sizes();
		write_sizes(2 ** SIZE_W - 1, 1);
		repeat (MAX_WIDTH + 2) send_pixel(draw_pixel());
		drain();
		write_sizes(4, 3);
		send_frame(1'b0, '0);
		drain();
	endtask

	// Receiver holds off for a long stretch while the sender pushes without gaps.
	task automatic test_output_backpressure();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		write_sizes(8, 8);
		rx_hold_request = HOLD_CYCLES;
		send_frame(1'b0, '0);
		send_frame(1'b0, '0);
		drain();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// Whole frames at random small sizes, templates and idling patterns.
	task automatic test_random_frames();
		int unsigned first;
		first = accepted_pixels;
		while (accepted_pixels - first < RANDOM_PIXELS) begin
			write_sizes($urandom_range(0, 14), $urandom_range(0, 7));
			if ($urandom_range(0, 3) != 0)
				write_template(TMPL_W'($urandom), TMPL_W'($urandom), TMPL_W'($urandom));
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(1, 2)) send_frame(1'b0, '0);
			drain();
		end
	endtask

	// Compare each accepted score with the oldest expected one.
	always @(posedge clk) begin : score_check
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_windows.size() == 0) begin
				$error("unexpected item: score %0d row %0d col %0d last %0d",
					score, win_row, win_col, frame_last);
				mismatch_count++;
			end else begin
				want = pending_windows.pop_front();
				if (score !== want.score) begin
					$error("score: expected %0d, got %0d", want.score, score);
					mismatch_count++;
				end
				if (win_row !== want.tag.win_row) begin
					$error("win_row: expected %0d, got %0d", want.tag.win_row, win_row);
					mismatch_count++;
				end
				if (win_col !== want.tag.win_col) begin
					$error("win_col: expected %0d, got %0d", want.tag.win_col, win_col);
					mismatch_count++;
				end
				if (frame_last !== want.tag.frame_last) begin
					$error("frame_last: expected %0d, got %0d", want.tag.frame_last,
						frame_last);
					mismatch_count++;
				end
			end
		end
	end

	// Output side: a random stall after each item when rx_idle is set, or a long hold when a test asks.
	initial begin : receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_request > 0) begin
				hold_left       = rx_hold_request;
				rx_hold_request = 0;
			end
			if (out_valid && !out_stall)
				stall_left = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) cycle_count++;

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : main
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		pixel     <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_size_change_mid_frame();
		test_smallest_sizes();
		test_template_extremes();
		test_template_mid_frame();
		test_unused_registers();
		test_largest_sizes();
		test_output_backpressure();
		test_random_frames();
		drain();

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
